### sv/shash_pkg.sv
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
// No dependencies; the top level and the round unit import this package.
package shash_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  // Control from the byte sequencer to the round unit
  typedef struct packed {
    logic start;
    logic init;
  } rnd_ctl_t;

  // Status back from the round unit
  typedef struct packed {
    logic busy;
    logic done;
  } rnd_sts_t;

  localparam hash_t IV = '{
    0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
    4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/shash_if.sv
// Valid/ready channel interfaces for the hasher: byte requests in, digest words out.
// Depends on nothing; used by the top level and by the testbench.
interface shash_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface shash_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### sv/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte stream hasher, top level: byte sequencer, block shift buffer, padding.
// Depends on shash_pkg, shash_if and shash_round.
//
// Usage: req_i takes one request per handshake: data_byte with byte_valid, and
// end_of_message on the final request of a message. A request with byte_valid low
// and end_of_message low does nothing. dig_o returns four 64-bit big-endian digest
// words (word_index 0..3, last_word on the fourth) after each end_of_message.
// A byte that does not complete a block is taken without a stall. The 64th byte
// of a block starts the shared round unit; req_i is not ready again until its
// rounds, final add and done handoff are through. On end_of_message the
// sequencer shifts padding and length bytes one per cycle (up to 64, or 72 with
// an extra block), each block followed by a compression; the first digest word
// then shows and each word leaves, one per cycle, while dig_o.ready is high.
// While digest words wait, req_i.ready stays low; a stalled receiver holds the word.
// After the fourth word the hash words return to the initial values.
// Reset clears the sequencer, fill count and bit count and loads the initial hash.
module sha256_byte_stream_hasher_unit (
  input logic         clk_i,
  input logic         rst_ni,
  shash_in_if.sink    req_i,
  shash_out_if.source dig_o
);
  import shash_pkg::*;

  typedef enum logic [4:0] {
    ST_IN    = 5'b00001,
    ST_COMP  = 5'b00010,
    ST_PAD   = 5'b00100,
    ST_PCOMP = 5'b01000,
    ST_OUT   = 5'b10000
  } shash_state_e;

  shash_state_e state_q;
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  logic         pend_last_q;
  logic         first_q;
  logic         extra_q;
  logic [1:0]   k_q;
  logic         start_q;
  logic         init_q;
  logic [511:0] buf_q;

  rnd_ctl_t ctl;
  rnd_sts_t sts;
  hash_t    hash;

  logic [5:0] fill_nx;
  logic [2:0] len_sel;
  logic [7:0] pad_byte;
  logic       shift_en;
  logic [7:0] shift_byte;
  logic       req_acc;

  assign req_acc = req_i.valid && (state_q == ST_IN);
  assign fill_nx = fill_q + 6'd1;
  assign len_sel = 3'd7 - fill_q[2:0];

  always_comb begin
    if (first_q) begin
      pad_byte = PAD_MARK;
    end else if (fill_q[5:3] == 3'b111 && !extra_q) begin
      pad_byte = bits_q[{len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = '0;
    end
    shift_en   = (req_acc && req_i.byte_valid) || (state_q == ST_PAD);
    shift_byte = (state_q == ST_PAD) ? pad_byte : req_i.data_byte;
  end

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      buf_q <= {buf_q[503:0], shift_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IN;
      fill_q      <= '0;
      bits_q      <= '0;
      pend_last_q <= 1'b0;
      first_q     <= 1'b0;
      extra_q     <= 1'b0;
      k_q         <= '0;
      start_q     <= 1'b0;
      init_q      <= 1'b0;
    end else begin
      start_q <= 1'b0;
      init_q  <= 1'b0;
      case (state_q)
        ST_IN: begin
          if (req_i.valid) begin
            if (req_i.byte_valid) begin
              fill_q <= fill_nx;
              bits_q <= bits_q + BYTE_BITS;
              if (fill_q == 6'd63) begin
                start_q     <= 1'b1;
                pend_last_q <= req_i.end_of_message;
                state_q     <= ST_COMP;
              end else if (req_i.end_of_message) begin
                first_q <= 1'b1;
                extra_q <= (fill_nx[5:3] == 3'b111);
                state_q <= ST_PAD;
              end
            end else if (req_i.end_of_message) begin
              first_q <= 1'b1;
              extra_q <= (fill_q[5:3] == 3'b111);
              state_q <= ST_PAD;
            end
          end
        end
        ST_COMP: begin
          if (sts.done) begin
            if (pend_last_q) begin
              first_q <= 1'b1;
              extra_q <= 1'b0;
              state_q <= ST_PAD;
            end else begin
              state_q <= ST_IN;
            end
          end
        end
        ST_PAD: begin
          fill_q  <= fill_nx;
          first_q <= 1'b0;
          if (fill_q == 6'd63) begin
            start_q <= 1'b1;
            state_q <= ST_PCOMP;
          end
        end
        ST_PCOMP: begin
          if (sts.done) begin
            if (extra_q) begin
              // marker took the length field's room: one more block of zeros and the length
              extra_q <= 1'b0;
              state_q <= ST_PAD;
            end else begin
              k_q     <= '0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (dig_o.ready) begin
            k_q <= k_q + 2'd1;
            if (k_q == 2'd3) begin
              init_q  <= 1'b1;
              bits_q  <= '0;
              state_q <= ST_IN;
            end
          end
        end
        default: state_q <= ST_IN;
      endcase
    end
  end

  assign ctl.start = start_q;
  assign ctl.init  = init_q;

  shash_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .block_i (buf_q),
    .sts_o   (sts),
    .hash_o  (hash)
  );

  assign req_i.ready       = (state_q == ST_IN);
  assign dig_o.valid       = (state_q == ST_OUT);
  assign dig_o.digest_word = {hash[{k_q, 1'b0}], hash[{k_q, 1'b1}]};
  assign dig_o.word_index  = k_q;
  assign dig_o.last_word   = (k_q == 2'd3);

endmodule

### sv/shash_round.sv
// Iterative SHA-256 compression: one round per cycle over a 16-word schedule window.
// Depends on shash_pkg; holds the eight hash words.
module shash_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  shash_pkg::rnd_ctl_t ctl_i,
  input  logic [511:0]        block_i,
  output shash_pkg::rnd_sts_t sts_o,
  output shash_pkg::hash_t    hash_o
);
  import shash_pkg::*;

  typedef enum logic [2:0] {
    RS_IDLE = 3'b001,
    RS_RUN  = 3'b010,
    RS_ADD  = 3'b100
  } rnd_state_e;

  rnd_state_e        state_q;
  logic [5:0]        rnd_q;
  logic              done_q;
  hash_t             hash_q;
  hash_t             v_q;
  logic [15:0][31:0] w_q;

  word_t t1, t2, w_new;

  always_comb begin
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + ROUND_K[rnd_q] + w_q[0];
    t2 = big_sigma0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      rnd_q   <= '0;
      done_q  <= 1'b0;
      hash_q  <= IV;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        RS_IDLE: begin
          if (ctl_i.init) begin
            hash_q <= IV;
          end else if (ctl_i.start) begin
            rnd_q   <= '0;
            state_q <= RS_RUN;
          end
        end
        RS_RUN: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            state_q <= RS_ADD;
          end
        end
        RS_ADD: begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + v_q[i];
          end
          done_q  <= 1'b1;
          state_q <= RS_IDLE;
        end
        default: state_q <= RS_IDLE;
      endcase
    end
  end

  // Working variables and schedule window carry no reset
  always_ff @(posedge clk_i) begin
    if (state_q == RS_IDLE && ctl_i.start && !ctl_i.init) begin
      v_q <= hash_q;
      for (int j = 0; j < 16; j++) begin
        w_q[j] <= block_i[511 - 32*j -: 32];
      end
    end else if (state_q == RS_RUN) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_new;
    end
  end

  assign sts_o.busy = (state_q != RS_IDLE);
  assign sts_o.done = done_q;
  assign hash_o     = hash_q;

endmodule

### sv/shash_checker.sv
// Port-level checks for the SHA-256 byte stream hasher, bound to the top level.
// Depends only on the top level's channel signals.
module shash_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_word_i,
  input logic [1:0]  out_index_i,
  input logic        out_last_i
);

  // hold a stalled digest word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i)
                                    && $stable(out_index_i))
    else $error("digest word changed while stalled");

  // no new request while digest words are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("request taken while digest pending");

  // advance the word index through a burst of four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      out_valid_i && out_index_i == $past(out_index_i) + 2'd1)
    else $error("digest burst broken");

  // last mark only on the fourth word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_index_i == 2'd3)))
    else $error("last_word mismatch");

  // after the last word, drop valid and take requests again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i && in_ready_i)
    else $error("no return to input after digest");

endmodule

bind sha256_byte_stream_hasher_unit shash_checker u_shash_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (dig_o.valid),
  .out_ready_i (dig_o.ready),
  .out_word_i  (dig_o.digest_word),
  .out_index_i (dig_o.word_index),
  .out_last_i  (dig_o.last_word)
);

### dv/tb_top.sv
// Self-checking testbench for the SHA-256 byte stream hasher: directed table, then random
// messages, checked against a behavioral SHA-256 predictor. Uses shash_in_if and shash_out_if.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned LONG_HOLD = 300;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] SEED_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Message lengths around the padding boundaries, cycled through by the random part
  localparam int unsigned EDGE_LENGTHS [4] = '{56, 64, 55, 63};

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         bv;
    logic         eom;
    logic         known;
    logic [255:0] dg;
  } dir_row_t;

  localparam int N_DIRECTED = 16;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message right after reset
    '{8'h3c, 1'b0, 1'b0, 1'b0, 256'h0},        // idle request
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},        // idle, byte ignored
    '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
    '{8'haa, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // finishing request, byte ignored
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h55, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h5a, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  shash_in_if  req_if ();
  shash_out_if dig_if ();

  sha256_byte_stream_hasher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .dig_o  (dig_if.source)
  );

  // Predictor state
  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  int unsigned  blk_fill;
  logic [63:0]  msg_bits;

  digest_beat_t pending_digest_words [$];
  int unsigned  errors;
  int unsigned  words_seen;
  int unsigned  requests_sent;
  int unsigned  messages_sent;
  logic [31:0]  cyc;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc <= '0;
    end else begin
      cyc <= cyc + 1;
    end
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] xx;
    xx = {x, x} >> n;
    return xx[31:0];
  endfunction

  function automatic void crunch_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int t = 0; t < 8; t++) v[t] = chain[t];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) chain[t] = chain[t] + v[t];
  endfunction

  function automatic void restart_hash();
    for (int t = 0; t < 8; t++) chain[t] = SEED_HASH[t];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  // Absorb one accepted request; return 1 with the digest when it closes a message
  function automatic bit absorb_request(input logic [7:0] b, input logic bv, input logic eom,
                                        output logic [255:0] dg);
    logic [63:0] total;
    int unsigned i;
    dg = '0;
    if (bv) begin
      blk[blk_fill] = b;
      blk_fill++;
      if (blk_fill == 64) begin
        crunch_block();
        msg_bits += 64'd512;
        blk_fill = 0;
      end
    end
    if (!eom) return 1'b0;
    total = msg_bits + 64'(blk_fill) * 64'd8;
    i = blk_fill;
    blk[i] = PAD_BYTE;
    i++;
    // no room for the length: flush an extra block
    if (i > 56) begin
      while (i < 64) begin
        blk[i] = 8'h00;
        i++;
      end
      crunch_block();
      i = 0;
    end
    while (i < 56) begin
      blk[i] = 8'h00;
      i++;
    end
    for (int k = 0; k < 8; k++) blk[56+k] = total[63-8*k -: 8];
    crunch_block();
    dg = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
    restart_hash();
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(8, 4);
    return $urandom_range(40, 12);
  endfunction

  task automatic send_request(input logic [7:0] b, input logic bv, input logic eom,
                              input int unsigned gap, input logic known,
                              input logic [255:0] known_dg);
    logic [255:0] dg;
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid          <= 1'b1;
    req_if.data_byte      <= b;
    req_if.byte_valid     <= bv;
    req_if.end_of_message <= eom;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (bv || eom) requests_sent++;
    if (absorb_request(b, bv, eom, dg)) begin
      if (known) dg = known_dg;
      messages_sent++;
      for (int k = 0; k < 4; k++) begin
        pending_digest_words.push_back('{word: dg[255-64*k -: 64], idx: 2'(k), last: k == 3});
      end
    end
  endtask

  // Digest word checker
  always @(posedge clk_i) begin : digest_check
    digest_beat_t head;
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      words_seen++;
      if (pending_digest_words.size() == 0) begin
        $error("digest word %h with nothing pending", dig_if.digest_word);
        errors++;
      end else begin
        head = pending_digest_words.pop_front();
        if (dig_if.digest_word !== head.word) begin
          $error("digest_word: expected %h, got %h", head.word, dig_if.digest_word);
          errors++;
        end
        if (dig_if.word_index !== head.idx) begin
          $error("word_index: expected %0d, got %0d", head.idx, dig_if.word_index);
          errors++;
        end
        if (dig_if.last_word !== head.last) begin
          $error("last_word: expected %0d, got %0d", head.last, dig_if.last_word);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off
  initial begin : digest_sink
    int unsigned hold;
    bit long_hold_done;
    hold = 0;
    long_hold_done = 1'b0;
    dig_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
        dig_if.ready <= 1'b0;
      end else if (!long_hold_done && words_seen >= 16) begin
        // hold off long enough for the hasher to back up into its input
        long_hold_done = 1'b1;
        hold = LONG_HOLD - 1;
        dig_if.ready <= 1'b0;
      end else if (cyc[8:7] == 2'b00 || $urandom_range(3, 0) != 0) begin
        dig_if.ready <= 1'b1;
      end else begin
        hold = gap_len() - 1;
        dig_if.ready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned rand_items;
    int unsigned rand_words;
    int unsigned msg_no;
    bit quiet_src;
    bit close_with_byte;
    logic eom;
    rst_ni = 1'b0;
    errors = 0;
    words_seen = 0;
    requests_sent = 0;
    messages_sent = 0;
    rand_items = 0;
    rand_words = 0;
    msg_no = 0;
    req_if.valid = 1'b0;
    req_if.data_byte = 8'h00;
    req_if.byte_valid = 1'b0;
    req_if.end_of_message = 1'b0;
    restart_hash();
    for (int t = 0; t < 64; t++) blk[t] = 8'h00;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_request(DIRECTED[r].data, DIRECTED[r].bv, DIRECTED[r].eom,
                   ($urandom_range(2, 0) == 0) ? gap_len() : 0,
                   DIRECTED[r].known, DIRECTED[r].dg);
    end

    while (rand_items < 130 || rand_words < 20) begin
      if (msg_no % 4 == 0) len = EDGE_LENGTHS[(msg_no / 4) % 4];
      else len = $urandom_range(12, 0);
      quiet_src = ($urandom_range(2, 0) == 0);
      close_with_byte = (len != 0) && ($urandom_range(1, 0) == 1);
      for (int j = 0; j < len; j++) begin
        // drop an idle request in now and then
        if ($urandom_range(19, 0) == 0) begin
          send_request(8'($urandom_range(255, 0)), 1'b0, 1'b0, 0, 1'b0, '0);
        end
        eom = close_with_byte && (j == len - 1);
        send_request(8'($urandom_range(255, 0)), 1'b1, eom,
                     (quiet_src || $urandom_range(2, 0) != 0) ? 0 : gap_len(), 1'b0, '0);
        rand_items++;
      end
      if (!close_with_byte) begin
        send_request(8'($urandom_range(255, 0)), 1'b0, 1'b1,
                     quiet_src ? 0 : gap_len(), 1'b0, '0);
        rand_items++;
      end
      rand_words += 4;
      msg_no++;
    end
    @(negedge clk_i);
    req_if.valid <= 1'b0;

    wait (pending_digest_words.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Run covered %0d byte and finishing requests over %0d messages,", requests_sent,
             messages_sent);
    $display("with %0d digest words checked, padding edges and a long output hold-off.",
             words_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
